[src/dpwm_pkg.sv]
package dpwm_pkg;

  // Command codes carried by an input beat.
  localparam logic [1:0] CMD_WRITE_A = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Register map.
  localparam int unsigned PADDR_W         = 2;
  localparam int unsigned PDATA_W         = 32;
  localparam int unsigned PERIOD_W        = 16;
  localparam logic [PADDR_W-1:0] REG_ADDR_PERIOD = 2'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd8999;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_WRITE_A,
    OP_WRITE_B,
    OP_TICK,
    OP_NONE
  } op_t;

  // One queued operation.
  typedef struct packed {
    op_t        op;
    logic [7:0] sample;
  } item_t;

endpackage

[src/dpwm_front.sv]
module dpwm_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [7:0]           sample,
  input  logic                 q_full,
  output logic                 push,
  output dpwm_pkg::item_t      push_item
);

  // Decode the raw command into an operation.
  function automatic dpwm_pkg::op_t classify(input logic [1:0] code);
    dpwm_pkg::op_t op;
    case (code)
      dpwm_pkg::CMD_WRITE_A: op = dpwm_pkg::OP_WRITE_A;
      dpwm_pkg::CMD_WRITE_B: op = dpwm_pkg::OP_WRITE_B;
      dpwm_pkg::CMD_TICK:    op = dpwm_pkg::OP_TICK;
      default:               op = dpwm_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  // A beat is taken whenever the queue has room.
  assign in_stall         = q_full;
  assign push             = in_valid && !q_full;
  assign push_item.op     = classify(cmd);
  assign push_item.sample = sample;

endmodule

[src/dpwm_queue.sv]
module dpwm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dpwm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dpwm_pkg::item_t head_item
);

  // Two-entry queue between front end and execution.
  dpwm_pkg::item_t slots [2];
  logic            wr_idx;
  logic            rd_idx;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_idx];

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/dpwm_back.sv]
module dpwm_back #(
  parameter int unsigned RING_DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dpwm_pkg::PERIOD_W-1:0] sample_period,
  input  logic                          head_valid,
  input  dpwm_pkg::item_t               head_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accepted,
  output logic [7:0]                    duty_a,
  output logic [7:0]                    duty_b,
  output logic                          sample_event,
  output logic                          running
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    n = (p == LAST) ? '0 : p + AW'(1);
    return n;
  endfunction

  // Ring storage; entries beyond the fill mark read as zero.
  logic [7:0] ring_a [RING_DEPTH];
  logic [7:0] ring_b [RING_DEPTH];
  logic [7:0] rdata_a;
  logic [7:0] rdata_b;

  // Architectural state.
  logic [AW-1:0]                 write_ptr_a, read_ptr_a, write_ptr_b, read_ptr_b;
  logic [AW-1:0]                 write_ptr_a_next, read_ptr_a_next;
  logic [AW-1:0]                 write_ptr_b_next, read_ptr_b_next;
  logic                          wrapped_a, wrapped_b, wrapped_a_next, wrapped_b_next;
  logic [dpwm_pkg::PERIOD_W-1:0] tick_count, tick_count_next;
  logic                          play_on, play_on_next;
  logic [7:0]                    duty_reg_a, duty_reg_b;

  // Result register.
  logic res_accepted, res_event, res_running, res_live_a, res_live_b;

  // Per-beat control.
  logic advance;
  logic we_a, we_b, do_pop, acc, live_a, live_b;
  logic take;

  assign advance = head_valid && (!out_valid || !out_stall);
  assign pop     = advance;
  assign take    = out_valid && !out_stall;

  // Execute the head operation against the current state.
  always_comb begin
    write_ptr_a_next = write_ptr_a;
    read_ptr_a_next  = read_ptr_a;
    write_ptr_b_next = write_ptr_b;
    read_ptr_b_next  = read_ptr_b;
    wrapped_a_next   = wrapped_a;
    wrapped_b_next   = wrapped_b;
    tick_count_next  = tick_count;
    play_on_next     = play_on;
    we_a             = 1'b0;
    we_b             = 1'b0;
    do_pop           = 1'b0;
    acc              = 1'b0;
    live_a           = wrapped_a || (read_ptr_a < write_ptr_a);
    live_b           = wrapped_b || (read_ptr_b < write_ptr_b);
    case (head_item.op)
      dpwm_pkg::OP_WRITE_A: begin
        if (ptr_next(write_ptr_a) != read_ptr_a) begin
          we_a             = 1'b1;
          acc              = 1'b1;
          write_ptr_a_next = ptr_next(write_ptr_a);
          wrapped_a_next   = wrapped_a || (write_ptr_a == LAST);
        end
      end
      dpwm_pkg::OP_WRITE_B: begin
        we_b             = 1'b1;
        acc              = 1'b1;
        write_ptr_b_next = ptr_next(write_ptr_b);
        wrapped_b_next   = wrapped_b || (write_ptr_b == LAST);
        play_on_next     = 1'b1;
      end
      dpwm_pkg::OP_TICK: begin
        acc = 1'b1;
        if (play_on) begin
          if (tick_count >= sample_period) begin
            tick_count_next = '0;
            do_pop          = 1'b1;
            read_ptr_a_next = ptr_next(read_ptr_a);
            read_ptr_b_next = ptr_next(read_ptr_b);
            play_on_next    = !((read_ptr_a_next == write_ptr_a) ||
                                (read_ptr_b_next == write_ptr_b));
          end else begin
            tick_count_next = tick_count + dpwm_pkg::PERIOD_W'(1);
          end
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  // Ring writes and registered pop reads; a read happens only as a beat moves on.
  always_ff @(posedge clk) begin
    if (advance && we_a) begin
      ring_a[write_ptr_a] <= head_item.sample;
    end
    if (advance && we_b) begin
      ring_b[write_ptr_b] <= head_item.sample;
    end
    if (advance && do_pop) begin
      rdata_a <= ring_a[read_ptr_a];
      rdata_b <= ring_b[read_ptr_b];
    end
  end

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr_a <= '0;
      read_ptr_a  <= '0;
      write_ptr_b <= '0;
      read_ptr_b  <= '0;
      wrapped_a   <= 1'b0;
      wrapped_b   <= 1'b0;
      tick_count  <= '0;
      play_on     <= 1'b0;
    end else if (advance) begin
      write_ptr_a <= write_ptr_a_next;
      read_ptr_a  <= read_ptr_a_next;
      write_ptr_b <= write_ptr_b_next;
      read_ptr_b  <= read_ptr_b_next;
      wrapped_a   <= wrapped_a_next;
      wrapped_b   <= wrapped_b_next;
      tick_count  <= tick_count_next;
      play_on     <= play_on_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_accepted <= acc;
      res_event    <= do_pop;
      res_running  <= play_on_next;
      res_live_a   <= live_a;
      res_live_b   <= live_b;
    end
  end

  // The duty registers pick up popped samples as the popping beat leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_reg_a <= '0;
      duty_reg_b <= '0;
    end else if (take && res_event) begin
      duty_reg_a <= duty_a;
      duty_reg_b <= duty_b;
    end
  end

  assign accepted     = res_accepted;
  assign sample_event = res_event;
  assign running      = res_running;
  assign duty_a       = res_event ? (res_live_a ? rdata_a : 8'd0) : duty_reg_a;
  assign duty_b       = res_event ? (res_live_b ? rdata_b : 8'd0) : duty_reg_b;

  // A pop beat is always a taken tick.
  a_event_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_event) |-> res_accepted)
    else $error("pop beat not marked accepted");

  // The timer only moves while playback runs.
  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    !play_on |=> $stable(tick_count))
    else $error("timer moved while stopped");

  // Read pointers move only on a pop.
  a_rptr_pop: assert property (@(posedge clk) disable iff (rst)
    !(advance && do_pop) |=> ($stable(read_ptr_a) && $stable(read_ptr_b)))
    else $error("read pointer moved without a pop");

  // A write to ring B always leaves playback running.
  a_write_b_runs: assert property (@(posedge clk) disable iff (rst)
    (advance && head_item.op == dpwm_pkg::OP_WRITE_B) |=> (play_on && res_running))
    else $error("ring B write did not start playback");

endmodule

[src/dual_pwm_sample_playback_fifo.sv]
// A beat accepted at the input is held in the queue, then executed into the result register.
// Throughput: one beat per cycle unless stalled; a beat does at most one ring write or pop.
// A two-entry queue lets input and output stall independently.
// Reset (synchronous): pointers, timer, playback and duties clear, period returns to 8999.
// The rings are not swept; fill marks make never-written entries read as zero.
module dual_pwm_sample_playback_fifo #(
  parameter int unsigned RING_DEPTH = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpwm_pkg::PADDR_W-1:0] paddr,
  input  logic [dpwm_pkg::PDATA_W-1:0] pwdata,
  output logic [dpwm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   cmd,
  input  logic [7:0]                   sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [7:0]                   duty_a,
  output logic [7:0]                   duty_b,
  output logic                         sample_event,
  output logic                         running
);

  logic [dpwm_pkg::PERIOD_W-1:0] sample_period;
  logic                          q_full, q_push, q_pop, q_head_valid;
  dpwm_pkg::item_t               q_push_item, q_head_item;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= dpwm_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && paddr == dpwm_pkg::REG_ADDR_PERIOD) begin
      sample_period <= pwdata[dpwm_pkg::PERIOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == dpwm_pkg::REG_ADDR_PERIOD) begin
      prdata = {{(dpwm_pkg::PDATA_W - dpwm_pkg::PERIOD_W){1'b0}}, sample_period};
    end
  end

  // Front end, queue and execution.
  dpwm_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sample    (sample),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_push_item)
  );

  dpwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  dpwm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .sample_period (sample_period),
    .head_valid    (q_head_valid),
    .head_item     (q_head_item),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .duty_a        (duty_a),
    .duty_b        (duty_b),
    .sample_event  (sample_event),
    .running       (running)
  );

endmodule
